FILE: sv/fmd_pkg.sv
package fmd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GAIN_W           = 16;
  localparam int OUT_W            = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
  localparam logic [OUT_W-1:0]  OUT_MAX    = 16'h7fff;
  localparam logic [OUT_W-1:0]  OUT_MIN    = 16'h8000;

  // accumulator update codes of the shared multiply unit
  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,
    MAC_SUB  = 2'd1,
    MAC_HI   = 2'd2,
    MAC_LO   = 2'd3
  } mac_op_t;

  typedef struct packed {
    logic    mul_en;
    logic    acc_en;
    mac_op_t op;
  } mac_ctrl_t;

endpackage

FILE: sv/fmd_diff.sv
module fmd_diff #(
  parameter int SW = fmd_pkg::SAMPLE_WIDTH_DEF,
  parameter int DW = SW + 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic signed [SW-1:0] in_re,
  input  logic signed [SW-1:0] in_im,
  output logic signed [DW-1:0] d_re,
  output logic signed [DW-1:0] d_im,
  output logic signed [SW-1:0] prev_re,
  output logic signed [SW-1:0] prev_im
);
  import fmd_pkg::*;

  // hist[0] is the newest sample once a request has been taken
  logic signed [SW-1:0] hist_re_r [4];
  logic signed [SW-1:0] hist_im_r [4];
  logic signed [DW-1:0] d_re_r, d_im_r;
  logic signed [DW-1:0] d_re_nxt, d_im_nxt;

  function automatic logic signed [DW-1:0] diff5(
    input logic signed [SW-1:0] x0,
    input logic signed [SW-1:0] x1,
    input logic signed [SW-1:0] x3,
    input logic signed [SW-1:0] x4
  );
    logic signed [SW:0]   a, b;
    logic signed [DW-1:0] ae, be;
    a  = {x1[SW-1], x1} - {x3[SW-1], x3};
    b  = {x0[SW-1], x0} - {x4[SW-1], x4};
    ae = {{(DW-SW-1){a[SW]}}, a};
    be = {{(DW-SW-1){b[SW]}}, b};
    // 31*a - 6*b
    return ((ae <<< 5) - ae) - ((be <<< 2) + (be <<< 1));
  endfunction

  always_comb begin
    d_re_nxt = diff5(in_re, hist_re_r[0], hist_re_r[2], hist_re_r[3]);
    d_im_nxt = diff5(in_im, hist_im_r[0], hist_im_r[2], hist_im_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        hist_re_r[k] <= '0;
        hist_im_r[k] <= '0;
      end
    end else if (load) begin
      hist_re_r[0] <= in_re;
      hist_im_r[0] <= in_im;
      for (int k = 1; k < 4; k++) begin
        hist_re_r[k] <= hist_re_r[k-1];
        hist_im_r[k] <= hist_im_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_re_r <= d_re_nxt;
      d_im_r <= d_im_nxt;
    end
  end

  assign d_re    = d_re_r;
  assign d_im    = d_im_r;
  assign prev_re = hist_re_r[1];
  assign prev_im = hist_im_r[1];

endmodule

FILE: sv/fmd_mac.sv
module fmd_mac #(
  parameter int A_W   = 23,
  parameter int B_W   = 17,
  parameter int ACC_W = 57,
  parameter int SPLIT = 17
) (
  input  logic                  clk,
  input  fmd_pkg::mac_ctrl_t    ctrl,
  input  logic signed [A_W-1:0] a,
  input  logic signed [B_W-1:0] b,
  output logic [ACC_W-1:0]      acc
);
  import fmd_pkg::*;

  localparam int P_W  = A_W + B_W;
  localparam int HI_W = ACC_W - SPLIT;

  logic signed [P_W-1:0] p_r;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [ACC_W-1:0]      p_ext;

  assign p_ext = {{(ACC_W-P_W){p_r[P_W-1]}}, p_r};

  always_comb begin
    unique case (ctrl.op)
      MAC_LOAD: acc_nxt = p_ext;
      MAC_SUB:  acc_nxt = acc_r - p_ext;
      // upper partial product lands above the kept low slice
      MAC_HI:   acc_nxt = {p_r[HI_W-1:0], acc_r[SPLIT-1:0]};
      MAC_LO:   acc_nxt = {acc_r[ACC_W-1:SPLIT], {SPLIT{1'b0}}} + p_ext;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p_r <= a * b;
    end
    if (ctrl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: sv/fm_demod_fir_differentiator.sv
// FM discriminator: a 5-tap antisymmetric differentiator (taps -6, 31, 0, -31, 6 on
// x[n]..x[n-4]) feeds the cross product Re(x[n-1])*Im(d) - Im(x[n-1])*Re(d), which is
// scaled by the unsigned Q4.12 gain, shifted right by 2*(SAMPLE_WIDTH-1)+5 (floor) and
// clamped to signed 16 bits. in_tdata carries in_phase in the low half and quadrature
// above it. in_tready stays low from acceptance until the clamp step is done, while one
// signed multiplier with a product register is used four times in turn (two cross-product
// terms, then the gain as an upper and a lower partial product), with a step to subtract
// the cross-product terms, one to add in the lower partial product and one for shift and
// clamp. The result sits in an output register, so a new sample is taken while it waits;
// only the clamp step stalls when that register is still full. The output is delayed by
// one sample, and there is no amplitude normalisation. gain resets to 1.0 and should only
// be written while no request is in flight.
module fm_demod_fir_differentiator #(
  parameter int SAMPLE_WIDTH = fmd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // in_phase, quadrature
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // demod
  output logic [fmd_pkg::OUT_W-1:0]            out_tdata,
  input  logic                                 cfg_we,
  input  logic [fmd_pkg::GAIN_W-1:0]           cfg_wdata
);
  import fmd_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int DW    = SW + 7;
  localparam int BW    = (SW > GAIN_W + 1) ? SW : GAIN_W + 1;
  localparam int CW    = 2 * SW + 8;
  localparam int SPLIT = SW + 1;
  localparam int ACC_W = CW + GAIN_W + 1;
  localparam int SH    = 2 * (SW - 1) + 5;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MUL_RE = 8'b0000_0010,
    ST_MUL_IM = 8'b0000_0100,
    ST_CROSS  = 8'b0000_1000,
    ST_MUL_HI = 8'b0001_0000,
    ST_MUL_LO = 8'b0010_0000,
    ST_ACC_LO = 8'b0100_0000,
    ST_SAT    = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [GAIN_W-1:0]    gain_r;
  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_tdata_r, out_tdata_nxt;
  logic                 accept, out_load;
  logic signed [DW-1:0] d_re, d_im;
  logic signed [SW-1:0] prev_re, prev_im;
  logic signed [DW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic [ACC_W-1:0]     acc;
  mac_ctrl_t            mac_ctrl;
  logic [ACC_W-SH-1:0]  res;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_SAT) && (!out_tvalid_r || out_tready);

  fmd_diff #(.SW(SW), .DW(DW)) u_diff (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .in_re   (in_tdata[SW-1:0]),
    .in_im   (in_tdata[2*SW-1:SW]),
    .d_re    (d_re),
    .d_im    (d_im),
    .prev_re (prev_re),
    .prev_im (prev_im)
  );

  always_comb begin
    mac_ctrl = '{mul_en: 1'b0, acc_en: 1'b0, op: MAC_LOAD};
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      ST_MUL_RE: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = d_im;
        mul_b           = BW'(prev_re);
      end
      ST_MUL_IM: begin
        mac_ctrl = '{mul_en: 1'b1, acc_en: 1'b1, op: MAC_LOAD};
        mul_a    = d_re;
        mul_b    = BW'(prev_im);
      end
      ST_CROSS: begin
        mac_ctrl = '{mul_en: 1'b0, acc_en: 1'b1, op: MAC_SUB};
      end
      ST_MUL_HI: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = acc[CW-1:SPLIT];
        mul_b           = BW'({1'b0, gain_r});
      end
      ST_MUL_LO: begin
        mac_ctrl = '{mul_en: 1'b1, acc_en: 1'b1, op: MAC_HI};
        mul_a    = {{(DW-SPLIT){1'b0}}, acc[SPLIT-1:0]};
        mul_b    = BW'({1'b0, gain_r});
      end
      ST_ACC_LO: begin
        mac_ctrl = '{mul_en: 1'b0, acc_en: 1'b1, op: MAC_LO};
      end
      default: begin
      end
    endcase
  end

  fmd_mac #(.A_W(DW), .B_W(BW), .ACC_W(ACC_W), .SPLIT(SPLIT)) u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mul_a),
    .b    (mul_b),
    .acc  (acc)
  );

  // floor shift, then clamp
  assign res = acc[ACC_W-1:SH];

  always_comb begin
    if (&res[ACC_W-SH-1:OUT_W-1] || !(|res[ACC_W-SH-1:OUT_W-1])) begin
      out_tdata_nxt = res[OUT_W-1:0];
    end else if (res[ACC_W-SH-1]) begin
      out_tdata_nxt = OUT_MIN;
    end else begin
      out_tdata_nxt = OUT_MAX;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_MUL_RE;
      ST_MUL_RE: state_nxt = ST_MUL_IM;
      ST_MUL_IM: state_nxt = ST_CROSS;
      ST_CROSS:  state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_ACC_LO;
      ST_ACC_LO: state_nxt = ST_SAT;
      ST_SAT:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gain_r       <= GAIN_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_MUL_RE)
    else $error("accepted request did not start the multiply sequence");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid_r && state_r == ST_IDLE)
    else $error("result not presented after clamp step");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready && state_r == ST_SAT |=> $stable(out_tdata_r))
    else $error("pending result overwritten");
`endif

endmodule
